[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define ACMAG_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("Assertion failed: implication does not hold.");

// Checks that a condition implies another once the delay dly has passed.
`define ACMAG_ASSERT_DLY(lbl, pre, dly, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##dly (post)) \
    else $error("Assertion failed: delayed implication does not hold.");

// Checks that a condition is never true.
`define ACMAG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("Assertion failed: forbidden condition seen.");

`endif

[hw/rtl/acmag_pkg.sv]
// Package with the types, constants and helpers of the acceleration scaling block.
package acmag_pkg;

  localparam int WORD_W   = 32;
  localparam int SCALE_W  = 24;
  localparam int SQ_W     = 63;
  localparam int SS_W     = 2 * SCALE_W;
  localparam int RATIO_W  = 48;
  localparam int PROD_W   = SQ_W + SS_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int DEN_W    = 64;
  localparam int ROOT_W   = 39;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int PASS_SHIFT = 32;

  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = RATIO_W;
  localparam int MUL_LAT   = 2;
  localparam int ROOT_LAT  = MUL_LAT + ROOT_W + 1;
  localparam int LATENCY   = FRONT_LAT + DIV_LAT + ROOT_LAT;

  localparam logic [1:0] REG_X_SCALE = 2'd0;
  localparam logic [1:0] REG_Y_SCALE = 2'd1;
  localparam logic [1:0] REG_Z_SCALE = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;
  localparam logic [WORD_W-1:0]  SAT_MAX     = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] vel_z;
    logic signed [WORD_W-1:0] accel_in;
    logic                     three_d;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] accel_out;
    logic                     saturated;
  } out_t;

  typedef struct packed {
    logic            pass;
    logic            neg;
    logic [SQ_W-1:0] aa;
  } side_t;

  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
  endfunction

endpackage

[hw/rtl/acmag_wmul.sv]
// Two-stage 63 by 48 bit unsigned multiplier built from four partial products.
module acmag_wmul import acmag_pkg::*; (
  input  logic              clk,
  input  logic [SQ_W-1:0]    a,
  input  logic [RATIO_W-1:0] b,
  output logic [PROD_W-1:0]  p
);

  logic [55:0] p_ll;
  logic [55:0] p_lh;
  logic [54:0] p_hl;
  logic [54:0] p_hh;

  always_ff @(posedge clk) begin
    p_ll <= a[31:0] * b[23:0];
    p_lh <= a[31:0] * b[47:24];
    p_hl <= a[62:32] * b[23:0];
    p_hh <= a[62:32] * b[47:24];
    p    <= PROD_W'(p_ll) + (PROD_W'(p_lh) << 24) + (PROD_W'(p_hl) << 32)
            + (PROD_W'(p_hh) << 56);
  end

endmodule

[hw/rtl/acmag_front.sv]
// Front pipeline: magnitudes, squares and the weighted numerator and denominator sums.
module acmag_front import acmag_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  in_t                          in_item,
  input  logic [2:0][SCALE_W-1:0]      scale,
  output logic                         out_vld,
  output logic [NUM_W-1:0]             num,
  output logic [DEN_W-1:0]             den,
  output side_t                        side
);

  logic [2:0][WORD_W-1:0] v1;
  logic [WORD_W-1:0]      a1;
  logic                   neg1, vld1;
  logic [2:0][SQ_W-1:0]   vs2;
  logic [2:0][SS_W-1:0]   ss2;
  logic [SQ_W-1:0]        aa2, aa3, aa4;
  logic                   neg2, neg3, neg4;
  logic                   vld2, vld3, vld4;
  logic [DEN_W-1:0]       d3, d4;
  logic [2:0][PROD_W-1:0] term;
  logic [2:0][63:0]       sqv;
  logic [2:0][SS_W-1:0]   sqs;
  logic [63:0]            sqa;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      out_vld <= vld4;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqv[i] = v1[i] * v1[i];
      sqs[i] = scale[i] * scale[i];
    end
    sqa = a1 * a1;
  end

  always_ff @(posedge clk) begin
    v1[0] <= mag32(in_item.vel_x);
    v1[1] <= mag32(in_item.vel_y);
    v1[2] <= in_item.three_d ? mag32(in_item.vel_z) : '0;
    a1    <= mag32(in_item.accel_in);
    neg1  <= in_item.accel_in[WORD_W-1];
    for (int i = 0; i < 3; i++) begin
      vs2[i] <= sqv[i][SQ_W-1:0];
      ss2[i] <= sqs[i];
    end
    aa2  <= sqa[SQ_W-1:0];
    neg2 <= neg1;
    d3   <= DEN_W'(vs2[0]) + DEN_W'(vs2[1]) + DEN_W'(vs2[2]);
    aa3  <= aa2;
    neg3 <= neg2;
    d4   <= d3;
    aa4  <= aa3;
    neg4 <= neg3;
    side.aa  <= aa4;
    side.neg <= neg4;
    if (d4 == '0) begin
      num       <= NUM_W'(1) << PASS_SHIFT;
      den       <= DEN_W'(1);
      side.pass <= 1'b1;
    end else begin
      num       <= NUM_W'(term[0]) + NUM_W'(term[1]) + NUM_W'(term[2]);
      den       <= d4;
      side.pass <= 1'b0;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    acmag_wmul u_mul (
      .clk (clk),
      .a   (vs2[g]),
      .b   (ss2[g]),
      .p   (term[g])
    );
  end

endmodule

[hw/rtl/acmag_div.sv]
// Restoring divider pipeline with one quotient bit per stage.
module acmag_div import acmag_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  input  side_t              in_side,
  output logic               out_vld,
  output logic [RATIO_W-1:0] quo,
  output side_t              out_side
);

  logic [DIV_LAT:0]              vld;
  logic [DIV_LAT:0][DEN_W-1:0]   rem;
  logic [DIV_LAT:0][RATIO_W-1:0] low;
  logic [DIV_LAT:0][DEN_W-1:0]   dv;
  logic [DIV_LAT:0][RATIO_W-1:0] q;
  side_t [DIV_LAT:0]             sd;

  assign vld[0] = in_vld;
  assign rem[0] = num[NUM_W-1:RATIO_W];
  assign low[0] = num[RATIO_W-1:0];
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign sd[0]  = in_side;

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem[j], low[j][RATIO_W-1]};
    assign diff  = trial - {1'b0, dv[j]};
    assign ge    = trial >= {1'b0, dv[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low[j+1] <= {low[j][RATIO_W-2:0], 1'b0};
      q[j+1]   <= {q[j][RATIO_W-2:0], ge};
      dv[j+1]  <= dv[j];
      sd[j+1]  <= sd[j];
    end
  end

  assign out_vld  = vld[DIV_LAT];
  assign quo      = q[DIV_LAT];
  assign out_side = sd[DIV_LAT];

endmodule

[hw/rtl/acmag_root.sv]
// Back pipeline: scales the squared acceleration, takes the square root, then saturates or restores the sign.
module acmag_root import acmag_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [RATIO_W-1:0] quo,
  input  side_t              in_side,
  output logic               out_vld,
  output out_t               result
);

  logic [PROD_W-1:0] prod;
  logic [MUL_LAT-1:0] mvld;
  logic [MUL_LAT-1:0] mpass, mneg;

  logic [ROOT_W:0]              vld;
  logic [ROOT_W:0][REM_W-1:0]   rem;
  logic [ROOT_W:0][ROOT_W-1:0]  rt;
  logic [ROOT_W:0][RAD_W-1:0]   rad;
  logic [ROOT_W:0]              pass;
  logic [ROOT_W:0]              neg;

  logic [WORD_W-1:0] low_root;
  logic              over;

  acmag_wmul u_mul (
    .clk (clk),
    .a   (in_side.aa),
    .b   (quo),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= '0;
    end else begin
      mvld <= {mvld[MUL_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    mpass <= {mpass[MUL_LAT-2:0], in_side.pass};
    mneg  <= {mneg[MUL_LAT-2:0], in_side.neg};
  end

  assign vld[0]  = mvld[MUL_LAT-1];
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign rad[0]  = prod[RAD_W+PASS_SHIFT-1:PASS_SHIFT];
  assign pass[0] = mpass[MUL_LAT-1];
  assign neg[0]  = mneg[MUL_LAT-1];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    assign cur   = {rem[j], rad[j][RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, rt[j], 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      rt[j+1]   <= {rt[j][ROOT_W-2:0], ge};
      rad[j+1]  <= {rad[j][RAD_W-3:0], 2'b00};
      pass[j+1] <= pass[j];
      neg[j+1]  <= neg[j];
    end
  end

  assign low_root = rt[ROOT_W][WORD_W-1:0];
  assign over     = rt[ROOT_W][ROOT_W-1:WORD_W-1] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (pass[ROOT_W]) begin
      result.accel_out <= neg[ROOT_W] ? (~low_root + WORD_W'(1)) : low_root;
      result.saturated <= 1'b0;
    end else if (over) begin
      result.accel_out <= SAT_MAX;
      result.saturated <= 1'b1;
    end else begin
      result.accel_out <= low_root;
      result.saturated <= 1'b0;
    end
  end

endmodule

[hw/rtl/anisotropic_accel_magnitude_scale.sv]
// Top level of the anisotropic acceleration magnitude scaling block.
// An item is accepted at a clock edge where start is high and busy is low.
// busy stays low: the pipeline takes a new item in every cycle.
// Each item yields one result, shown on result for exactly one cycle with
// done high, after passing in order through the magnitudes, squares and
// weighted sums, the divider (one quotient bit per stage), the final
// multiplier, the square root (one root bit per stage) and one output
// register.
// Throughput is one item per cycle; results leave in the order of entry.
// The receiver cannot stall, so the pipeline never holds.
// The scale registers are written through the cfg channel (index 0 x_scale,
// 1 y_scale, 2 z_scale, other indexes ignored); cfg_ready is always high,
// and the registers should only change while no item is in flight.
// Reset clears all pipeline valid bits, so no result appears for items
// accepted before it, and sets each scale register to 1.0.
module anisotropic_accel_magnitude_scale import acmag_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_t                operand,
  output logic               done,
  output out_t               result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [SCALE_W-1:0] cfg_data
);

  logic [2:0][SCALE_W-1:0] scale;
  logic                    f_vld, d_vld;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  side_t                   f_side, d_side;
  logic [RATIO_W-1:0]      quo;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= {3{SCALE_RESET}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_SCALE: scale[0] <= cfg_data;
        REG_Y_SCALE: scale[1] <= cfg_data;
        REG_Z_SCALE: scale[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  acmag_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start && !busy),
    .in_item (operand),
    .scale   (scale),
    .out_vld (f_vld),
    .num     (num),
    .den     (den),
    .side    (f_side)
  );

  acmag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .num      (num),
    .den      (den),
    .in_side  (f_side),
    .out_vld  (d_vld),
    .quo      (quo),
    .out_side (d_side)
  );

  acmag_root u_root (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (d_vld),
    .quo     (quo),
    .in_side (d_side),
    .out_vld (done),
    .result  (result)
  );

endmodule

[hw/rtl/acmag_checker.sv]
// Port-level checker for the acceleration scaling block, bound to its top level.
`include "assert_macros.svh"

module acmag_checker import acmag_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input out_t               result,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  `ACMAG_ASSERT_NEVER(a_never_busy, busy)
  `ACMAG_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)
  `ACMAG_ASSERT_IMP(a_sat_value, done && result.saturated, result.accel_out == SAT_MAX)
  `ACMAG_ASSERT_DLY(a_result_follows, start && !busy, LATENCY, done)
  `ACMAG_ASSERT_IMP(a_no_spurious, done, $past(start, LATENCY))

endmodule

bind anisotropic_accel_magnitude_scale acmag_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
